@@ src/padq_pkg.sv @@
`timescale 1ns / 1ps
package padq_pkg;

	// queue depth and derived widths
	localparam int ALARMS = 8;
	localparam int IdxW   = $clog2(ALARMS);
	localparam int CntW   = $clog2(ALARMS + 1);
	localparam int IdW    = 3;
	localparam int TickW  = 32;

	// per-cell operations, broadcast down the chain
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_DROP  = 2'd1;
	localparam logic [1:0] OP_PLACE = 2'd2;
	localparam logic [1:0] OP_POP   = 2'd3;

	// request item
	typedef struct packed {
		logic             req_type;
		logic [IdW-1:0]   alarm_id;
		logic [TickW-1:0] deadline;
		logic [TickW-1:0] period_ticks;
	} req_t;

	// fired alarm item
	typedef struct packed {
		logic [IdW-1:0]   fired_id;
		logic [TickW-1:0] tick_now;
		logic             last;
	} fire_t;

	// one queue slot
	typedef struct packed {
		logic             valid;
		logic [IdW-1:0]   alarm;
		logic [TickW-1:0] deadline;
		logic [TickW-1:0] period;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic [1:0]       op;
		logic [IdW-1:0]   alarm;
		logic [TickW-1:0] deadline;
		logic [TickW-1:0] period;
		logic [TickW-1:0] now;
	} cmd_t;

	// true when a - b, taken as signed, is greater than zero
	function automatic logic later_than(input logic [TickW-1:0] a, input logic [TickW-1:0] b);
		logic [TickW-1:0] d;
		d = a - b;
		return (d != '0) && !d[TickW-1];
	endfunction

endpackage

@@ src/padq_cell.sv @@
`timescale 1ns / 1ps
module padq_cell import padq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t left,
	input  entry_t right,
	input  logic   hit_in,
	input  logic   place_in,
	output logic   hit_out,
	output logic   place_out,
	output entry_t ent,
	output logic   due
);

	logic             valid_q;
	logic [IdW-1:0]   alarm_q;
	logic [TickW-1:0] deadline_q;
	logic [TickW-1:0] period_q;
	entry_t           cur;
	entry_t           nxt;
	logic             match;
	logic             stop;

	// current slot contents
	assign cur = {valid_q, alarm_q, deadline_q, period_q};

	// local compares against the broadcast command
	assign match     = cur.valid && (cur.alarm == cmd.alarm);
	assign hit_out   = hit_in | match;
	assign stop      = !cur.valid || !later_than(cmd.deadline, cur.deadline);
	assign place_out = place_in | stop;
	assign due       = cur.valid && !later_than(cur.deadline, cmd.now);
	assign ent       = cur;

	// pick next contents: hold, take a neighbor, or take the new entry
	always_comb begin
		nxt = cur;
		case (cmd.op)
			OP_DROP: begin
				if (hit_out) begin
					nxt = right;
				end
			end
			OP_PLACE: begin
				if (place_in) begin
					nxt = left;
				end else if (stop) begin
					nxt.valid    = 1'b1;
					nxt.alarm    = cmd.alarm;
					nxt.deadline = cmd.deadline;
					nxt.period   = cmd.period;
				end
			end
			OP_POP: begin
				nxt = right;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		alarm_q    <= nxt.alarm;
		deadline_q <= nxt.deadline;
		period_q   <= nxt.period;
	end

endmodule

@@ src/periodic_alarm_deadline_queue_core.sv @@
`timescale 1ns / 1ps
// Schedule item: accept, drop old entry of that id, place in order.
// Tick item: count, then fire each due alarm while the output is free (fire_valid low or fire_ready
// high), end the firing run, then re-queue each periodic alarm (load, drop, place) and return to idle.
// One item is worked at a time; req_ready is high only while idle.
// Reset: tick count zero, queue and reload buffer empty; no clearing pass needed.
module periodic_alarm_deadline_queue_core import padq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  fire_valid,
	input  logic  fire_ready,
	output fire_t fire
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DROP   = 3'd1;
	localparam logic [2:0] ST_PLACE  = 3'd2;
	localparam logic [2:0] ST_POP    = 3'd3;
	localparam logic [2:0] ST_RELOAD = 3'd4;

	logic [2:0]       state_q;
	logic [TickW-1:0] count_q;
	logic [CntW-1:0]  rl_cnt_q;
	logic             reload_q;
	logic             out_valid_q;
	fire_t            out_q;
	entry_t           pend_q;
	entry_t           rl_q [ALARMS];

	cmd_t             cmd;
	entry_t           ent    [ALARMS];
	logic             due    [ALARMS];
	logic             hit    [ALARMS+1];
	logic             place  [ALARMS+1];
	entry_t           empty_ent;

	logic             req_acc;
	logic             out_free;
	logic             fire_now;
	logic             push_rl;
	logic             pop_rl;
	logic             full;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_acc    = req_valid && req_ready;
	assign fire_valid = out_valid_q;
	assign fire       = out_q;
	assign out_free   = !out_valid_q || fire_ready;
	assign full       = ent[ALARMS-1].valid;
	assign fire_now   = (state_q == ST_POP) && due[0] && out_free;
	assign push_rl    = fire_now && (ent[0].period != '0);
	assign pop_rl     = (state_q == ST_RELOAD) && (rl_cnt_q != '0);
	assign empty_ent  = '0;

	// broadcast command to the chain
	always_comb begin
		cmd.alarm    = pend_q.alarm;
		cmd.deadline = pend_q.deadline;
		cmd.period   = pend_q.period;
		cmd.now      = count_q;
		case (state_q)
			ST_DROP:  cmd.op = OP_DROP;
			ST_PLACE: cmd.op = full ? OP_HOLD : OP_PLACE;
			ST_POP:   cmd.op = fire_now ? OP_POP : OP_HOLD;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	// chain of queue cells, head at index zero
	assign hit[0]   = 1'b0;
	assign place[0] = 1'b0;

	for (genvar i = 0; i < ALARMS; i++) begin : g_cell
		entry_t l_ent;
		entry_t r_ent;
		if (i == 0) begin : g_head
			assign l_ent = empty_ent;
		end else begin : g_mid
			assign l_ent = ent[i-1];
		end
		if (i == ALARMS - 1) begin : g_tail
			assign r_ent = empty_ent;
		end else begin : g_body
			assign r_ent = ent[i+1];
		end
		padq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left     (l_ent),
			.right    (r_ent),
			.hit_in   (hit[i]),
			.place_in (place[i]),
			.hit_out  (hit[i+1]),
			.place_out(place[i+1]),
			.ent      (ent[i]),
			.due      (due[i])
		);
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rl_cnt_q    <= '0;
			reload_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_now) begin
				out_valid_q <= 1'b1;
			end else if (fire_ready) begin
				out_valid_q <= 1'b0;
			end
			if (push_rl) begin
				rl_cnt_q <= rl_cnt_q + CntW'(1);
			end else if (pop_rl) begin
				rl_cnt_q <= rl_cnt_q - CntW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.req_type) begin
							reload_q <= 1'b0;
							state_q  <= ST_DROP;
						end else begin
							count_q <= count_q + TickW'(1);
							state_q <= ST_POP;
						end
					end
				end
				ST_DROP: begin
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					state_q <= reload_q ? ST_RELOAD : ST_IDLE;
				end
				ST_POP: begin
					if (!due[0]) begin
						reload_q <= 1'b1;
						state_q  <= ST_RELOAD;
					end
				end
				ST_RELOAD: begin
					state_q <= pop_rl ? ST_DROP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pending entry, reload buffer and output item
	always_ff @(posedge clk) begin
		if (req_acc) begin
			pend_q.valid    <= 1'b1;
			pend_q.alarm    <= req.alarm_id;
			pend_q.deadline <= req.deadline;
			pend_q.period   <= req.period_ticks;
		end else if (pop_rl) begin
			pend_q <= rl_q[0];
		end
		if (push_rl) begin
			rl_q[rl_cnt_q[IdxW-1:0]].valid    <= 1'b1;
			rl_q[rl_cnt_q[IdxW-1:0]].alarm    <= ent[0].alarm;
			rl_q[rl_cnt_q[IdxW-1:0]].deadline <= ent[0].deadline + ent[0].period;
			rl_q[rl_cnt_q[IdxW-1:0]].period   <= ent[0].period;
		end else if (pop_rl) begin
			for (int i = 0; i < ALARMS - 1; i++) begin
				rl_q[i] <= rl_q[i+1];
			end
		end
		if (fire_now) begin
			out_q.fired_id <= ent[0].alarm;
			out_q.tick_now <= count_q;
			out_q.last     <= !due[1];
		end
	end

endmodule
